// ===== rtl/msch_pkg.sv =====
package msch_pkg;

  localparam int MaxVertsDef  = 8;
  localparam int CoordBitsDef = 16;
  localparam int SmallSet     = 3;
  localparam int ResultCap    = 64;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_SMALL,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_HULL_RD,
    ST_HULL_TURN,
    ST_HULL_MUL,
    ST_HULL_DEC,
    ST_EMIT_RD,
    ST_EMIT
  } back_state_e;

endpackage

// ===== rtl/msch_front.sv =====
module msch_front #(
  parameter int CoordBits = msch_pkg::CoordBitsDef,
  parameter int QDepth    = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  logic                 func_i,
  input  logic [CoordBits-1:0] vertex_x_i,
  input  logic [CoordBits-1:0] vertex_y_i,
  input  logic                 final_vertex_i,
  output logic                 q_valid_o,
  input  logic                 q_pop_i,
  output logic                 q_func_o,
  output logic [CoordBits:0]   q_x_o,
  output logic [CoordBits:0]   q_y_o,
  output logic                 q_final_o,
  output logic                 q_full_o
);
  localparam int EW = 2 + 2 * (CoordBits + 1);
  localparam int PW = $clog2(QDepth);
  logic [EW-1:0] mem_q [QDepth];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0]   cnt_q;
  logic          push;
  logic [CoordBits:0] xe, ye;
  logic [EW-1:0] rd;

  // negate moving vertices on the way in, one extra bit holds plus full scale
  always_comb begin
    xe = {vertex_x_i[CoordBits-1], vertex_x_i};
    ye = {vertex_y_i[CoordBits-1], vertex_y_i};
    if (func_i) begin
      xe = -xe;
      ye = -ye;
    end
  end

  assign push = start_i && !busy_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= {func_i, final_vertex_i, xe, ye};
  end

  // advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == PW'(QDepth - 1)) ? '0 : wp_q + 1'b1;
      if (q_pop_i) rp_q <= (rp_q == PW'(QDepth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(q_pop_i);
    end
  end

  assign rd        = mem_q[rp_q];
  assign q_valid_o = (cnt_q != '0);
  assign q_full_o  = (cnt_q == (PW+1)'(QDepth));
  assign q_func_o  = rd[EW-1];
  assign q_final_o = rd[EW-2];
  assign q_x_o     = rd[2*(CoordBits+1)-1 -: CoordBits+1];
  assign q_y_o     = rd[CoordBits:0];

  always_ff @(posedge clk_i) begin
    if (rst_ni) begin
      assert (!(q_pop_i && !q_valid_o)) else $error("pop from empty queue");
    end
  end
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full_o |-> !push) else $error("push into full queue");
  a_cnt_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PW+1)'(QDepth)) else $error("count out of range");
  a_pop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_i && !push) |=> cnt_q == $past(cnt_q) - 1'b1) else $error("count slip");
endmodule

// ===== rtl/msch_ram.sv =====
module msch_ram #(
  parameter int Width = 34,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/msch_back.sv =====
module msch_back #(
  parameter int MaxVerts  = msch_pkg::MaxVertsDef,
  parameter int CoordBits = msch_pkg::CoordBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_pop_o,
  input  logic               q_func_i,
  input  logic [CoordBits:0] q_x_i,
  input  logic [CoordBits:0] q_y_i,
  input  logic               q_final_i,
  output logic               idle_o,
  output logic               done_o,
  output logic [CoordBits:0] hull_x_o,
  output logic [CoordBits:0] hull_y_o,
  output logic               hull_empty_o,
  output logic               overflowed_o,
  output logic               last_of_hull_o
);
  localparam int CW   = CoordBits + 1;
  localparam int PW   = 2 * CW;
  localparam int VW   = (MaxVerts > 1) ? $clog2(MaxVerts) : 1;
  localparam int CNTW = $clog2(MaxVerts + 1);
  localparam int NS   = MaxVerts * MaxVerts;
  localparam int SW   = (NS > 1) ? $clog2(NS) : 1;
  localparam int NW   = $clog2(NS + 1);
  localparam int SD   = 2 * NS + 2;
  localparam int KW   = $clog2(SD + 1);
  localparam int KA   = $clog2(SD);
  localparam int DW   = CW + 1;
  localparam int MW   = 2 * DW;

  logic [CW-1:0] fx_q [MaxVerts];
  logic [CW-1:0] fy_q [MaxVerts];
  logic [CW-1:0] mx_q [MaxVerts];
  logic [CW-1:0] my_q [MaxVerts];
  logic [CNTW-1:0] fcnt_q, fcnt_d, mcnt_q, mcnt_d;
  logic ovf_q, ovf_d;

  msch_pkg::back_state_e st_q, st_d;
  logic [NW-1:0] n_q, n_d, i_q, i_d, j_q, j_d;
  logic [VW-1:0] fi_q, fi_d, mj_q, mj_d;
  logic [KW-1:0] k_q, k_d, t_q, t_d;
  logic          upper_q, upper_d;
  logic [PW-1:0] p_q, p_d;
  logic [PW-1:0] a_q, a_d, b_q, b_d;
  logic signed [MW-1:0] m1_q, m2_q;
  logic [1:0]    rdph_q, rdph_d;

  // sum and stack ram ports
  logic          s_we;
  logic [SW-1:0] s_wa, s_ra;
  logic [PW-1:0] s_wd, s_rd;
  logic          h_we;
  logic [KA-1:0] h_wa, h_ra;
  logic [PW-1:0] h_wd, h_rd;

  msch_ram #(.Width(PW), .Depth(NS)) u_sum (
    .clk_i, .we_i(s_we), .waddr_i(s_wa), .wdata_i(s_wd), .raddr_i(s_ra), .rdata_o(s_rd));
  msch_ram #(.Width(PW), .Depth(SD)) u_stk (
    .clk_i, .we_i(h_we), .waddr_i(h_wa), .wdata_i(h_wd), .raddr_i(h_ra), .rdata_o(h_rd));

  function automatic logic lt(input logic [PW-1:0] a, input logic [PW-1:0] b);
    logic signed [CW-1:0] ax, ay, bx, by;
    ax = a[PW-1:CW]; ay = a[CW-1:0]; bx = b[PW-1:CW]; by = b[CW-1:0];
    return (ax < bx) || (ax == bx && ay < by);
  endfunction

  function automatic logic signed [DW-1:0] dx(input logic [PW-1:0] a, input logic [PW-1:0] o);
    return DW'($signed(a[PW-1:CW])) - DW'($signed(o[PW-1:CW]));
  endfunction
  function automatic logic signed [DW-1:0] dy(input logic [PW-1:0] a, input logic [PW-1:0] o);
    return DW'($signed(a[CW-1:0])) - DW'($signed(o[CW-1:0]));
  endfunction

  logic signed [CW-1:0] sx, sy;
  logic signed [MW:0]   cr;
  logic                 is_new;

  // sum of the current fixed and moving pair
  assign sx = $signed(fx_q[fi_q]) + $signed(mx_q[mj_q]);
  assign sy = $signed(fy_q[fi_q]) + $signed(my_q[mj_q]);
  assign cr = (MW+1)'(m1_q) - (MW+1)'(m2_q);
  assign is_new = q_valid_i && st_q == msch_pkg::ST_IDLE;

  // vertex stores
  always_ff @(posedge clk_i) begin
    if (is_new && !q_func_i && fcnt_q < CNTW'(MaxVerts)) begin
      fx_q[fcnt_q[VW-1:0]] <= q_x_i;
      fy_q[fcnt_q[VW-1:0]] <= q_y_i;
    end
    if (is_new && q_func_i && mcnt_q < CNTW'(MaxVerts)) begin
      mx_q[mcnt_q[VW-1:0]] <= q_x_i;
      my_q[mcnt_q[VW-1:0]] <= q_y_i;
    end
  end

  // cross product partial products, registered
  always_ff @(posedge clk_i) begin
    m1_q <= dx(b_q, a_q) * dy(p_q, a_q);
    m2_q <= dy(b_q, a_q) * dx(p_q, a_q);
  end

  // next state and datapath control
  always_comb begin
    st_d = st_q; fcnt_d = fcnt_q; mcnt_d = mcnt_q; ovf_d = ovf_q;
    n_d = n_q; i_d = i_q; j_d = j_q; fi_d = fi_q; mj_d = mj_q;
    k_d = k_q; t_d = t_q; upper_d = upper_q; p_d = p_q; a_d = a_q; b_d = b_q;
    rdph_d = rdph_q;
    s_we = 1'b0; s_wa = n_q[SW-1:0]; s_wd = {sx, sy}; s_ra = i_q[SW-1:0];
    h_we = 1'b0; h_wa = k_q[KA-1:0]; h_wd = p_q; h_ra = '0;
    q_pop_o = 1'b0;
    unique case (st_q)
      msch_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (!q_func_i) begin
            if (fcnt_q < CNTW'(MaxVerts)) fcnt_d = fcnt_q + 1'b1; else ovf_d = 1'b1;
          end else begin
            if (mcnt_q < CNTW'(MaxVerts)) mcnt_d = mcnt_q + 1'b1; else ovf_d = 1'b1;
          end
          if (q_final_i) begin
            n_d = '0; fi_d = '0; mj_d = '0;
            if (fcnt_d == '0 || mcnt_d == '0) begin
              i_d = '0; st_d = msch_pkg::ST_EMIT;
            end else st_d = msch_pkg::ST_SUM;
          end
        end
      end
      msch_pkg::ST_SUM: begin
        s_we = 1'b1;
        n_d = n_q + 1'b1;
        if (CNTW'(mj_q) == mcnt_q - 1'b1) begin
          mj_d = '0;
          if (CNTW'(fi_q) == fcnt_q - 1'b1) begin
            i_d = '0; rdph_d = '0;
            if (n_d <= NW'(msch_pkg::SmallSet)) st_d = msch_pkg::ST_SMALL;
            else begin i_d = NW'(1); st_d = msch_pkg::ST_SORT_RD; end
          end else fi_d = fi_q + 1'b1;
        end else mj_d = mj_q + 1'b1;
      end
      msch_pkg::ST_SMALL: begin
        // read sum i, then emit it next cycle
        s_ra = i_q[SW-1:0];
        if (rdph_q == 2'd0) rdph_d = 2'd1;
        else begin
          rdph_d = 2'd0;
          i_d = i_q + 1'b1;
          if (i_d == n_q) st_d = msch_pkg::ST_IDLE;
        end
      end
      msch_pkg::ST_SORT_RD: begin
        // insertion sort: fetch p = s[i] and then s[j-1]
        if (rdph_q == 2'd0) begin
          s_ra = i_q[SW-1:0]; rdph_d = 2'd1; j_d = i_q;
        end else if (rdph_q == 2'd1) begin
          p_d = s_rd; s_ra = SW'(j_q - 1'b1); rdph_d = 2'd2;
        end else begin
          s_ra = SW'(j_q - 1'b1); st_d = msch_pkg::ST_SORT_CMP;
        end
      end
      msch_pkg::ST_SORT_CMP: begin
        if (j_q != '0 && lt(p_q, s_rd)) begin
          s_we = 1'b1; s_wa = j_q[SW-1:0]; s_wd = s_rd;
          j_d = j_q - 1'b1;
          s_ra = SW'(j_d - 1'b1);
          st_d = (j_d == '0) ? msch_pkg::ST_SORT_CMP : msch_pkg::ST_SORT_RD;
          rdph_d = 2'd2;
        end else begin
          s_we = 1'b1; s_wa = j_q[SW-1:0]; s_wd = p_q;
          rdph_d = 2'd0;
          i_d = i_q + 1'b1;
          if (i_d == n_q) begin
            i_d = '0; k_d = '0; upper_d = 1'b0; st_d = msch_pkg::ST_HULL_RD;
          end else st_d = msch_pkg::ST_SORT_RD;
        end
      end
      msch_pkg::ST_HULL_RD: begin
        // fetch point i, then stack top two
        s_ra = i_q[SW-1:0];
        if (rdph_q == 2'd0) rdph_d = 2'd1;
        else if (rdph_q == 2'd1) begin
          p_d = s_rd; h_ra = KA'(k_q - 2'd2); rdph_d = 2'd2;
        end else if (rdph_q == 2'd2) begin
          a_d = h_rd; h_ra = KA'(k_q - 1'b1); rdph_d = 2'd3;
        end else begin
          b_d = h_rd; rdph_d = 2'd0; st_d = msch_pkg::ST_HULL_TURN;
        end
        if (rdph_q == 2'd1 && !(upper_q ? (k_q >= t_q) : (k_q >= KW'(2)))) begin
          rdph_d = 2'd0; st_d = msch_pkg::ST_HULL_DEC;
        end
      end
      msch_pkg::ST_HULL_TURN: begin
        // a wait for the registered products
        st_d = msch_pkg::ST_HULL_MUL;
      end
      msch_pkg::ST_HULL_MUL: begin
        if (cr <= 0) begin
          k_d = k_q - 1'b1;
          rdph_d = 2'd1;
          s_ra = i_q[SW-1:0];
          st_d = msch_pkg::ST_HULL_RD;
        end else st_d = msch_pkg::ST_HULL_DEC;
      end
      msch_pkg::ST_HULL_DEC: begin
        // push point and advance the chain
        h_we = 1'b1; h_wa = k_q[KA-1:0]; h_wd = p_q;
        k_d = k_q + 1'b1;
        st_d = msch_pkg::ST_HULL_RD;
        rdph_d = 2'd0;
        if (!upper_q) begin
          if (i_q == n_q - 1'b1) begin
            upper_d = 1'b1; t_d = k_d + 1'b1;
            i_d = n_q - 2'd2;
          end else i_d = i_q + 1'b1;
        end else begin
          if (i_q == '0) begin
            i_d = '0; st_d = msch_pkg::ST_EMIT_RD;
            if (k_d - 1'b1 > KW'(msch_pkg::ResultCap)) n_d = NW'(msch_pkg::ResultCap);
            else n_d = NW'(k_d - 1'b1);
          end else i_d = i_q - 1'b1;
        end
      end
      msch_pkg::ST_EMIT_RD: begin
        h_ra = KA'(i_q);
        if (rdph_q == 2'd0) rdph_d = 2'd1;
        else begin
          rdph_d = 2'd0;
          i_d = i_q + 1'b1;
          if (i_d == n_q) st_d = msch_pkg::ST_IDLE;
        end
      end
      msch_pkg::ST_EMIT: st_d = msch_pkg::ST_IDLE;
      default: st_d = msch_pkg::ST_IDLE;
    endcase
    if (st_q != msch_pkg::ST_IDLE && st_d == msch_pkg::ST_IDLE) begin
      fcnt_d = '0; mcnt_d = '0; ovf_d = 1'b0;
    end
  end

  // result outputs
  always_comb begin
    done_o = 1'b0; hull_x_o = '0; hull_y_o = '0; hull_empty_o = 1'b0;
    last_of_hull_o = 1'b0;
    overflowed_o = ovf_q;
    unique case (st_q)
      msch_pkg::ST_EMIT: begin
        done_o = 1'b1; hull_empty_o = 1'b1; last_of_hull_o = 1'b1;
      end
      msch_pkg::ST_SMALL: begin
        done_o = (rdph_q == 2'd1);
        {hull_x_o, hull_y_o} = s_rd;
        last_of_hull_o = (i_q + 1'b1 == n_q);
      end
      msch_pkg::ST_EMIT_RD: begin
        done_o = (rdph_q == 2'd1);
        {hull_x_o, hull_y_o} = h_rd;
        last_of_hull_o = (i_q + 1'b1 == n_q);
      end
      default: ;
    endcase
  end

  assign idle_o = (st_q == msch_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= msch_pkg::ST_IDLE; fcnt_q <= '0; mcnt_q <= '0; ovf_q <= 1'b0;
      n_q <= '0; i_q <= '0; j_q <= '0; fi_q <= '0; mj_q <= '0;
      k_q <= '0; t_q <= '0; upper_q <= 1'b0; rdph_q <= '0;
    end else begin
      st_q <= st_d; fcnt_q <= fcnt_d; mcnt_q <= mcnt_d; ovf_q <= ovf_d;
      n_q <= n_d; i_q <= i_d; j_q <= j_d; fi_q <= fi_d; mj_q <= mj_d;
      k_q <= k_d; t_q <= t_d; upper_q <= upper_d; rdph_q <= rdph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d; a_q <= a_d; b_q <= b_d;
  end

  a_cnt_f: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q <= CNTW'(MaxVerts)) else $error("fixed count out of range");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> idle_o) else $error("pop while busy");
  a_done_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && last_of_hull_o) |=> (fcnt_q == '0 && !ovf_q)) else $error("no clear");
endmodule

// ===== rtl/minkowski_sum_convex_hull.sv =====
// channel   ports                                              direction
// command   start_i, func_i, vertex_x_i, vertex_y_i,           in
//           final_vertex_i (busy_o is out)
// result    hull_valid_o, hull_x_o, hull_y_o, hull_empty_o,    out
//           overflowed_o, last_of_hull_o
// A load is registered in the command queue and is taken by the hull engine
// once it is idle. The final vertex starts the sum pass (one sum per cycle),
// an insertion sort and the monotone chain, all bound by the single read port
// of the sum and stack memories; with either set empty an empty hull is
// reported instead, and with 3 sums or fewer the sums are emitted unsorted.
// Results cannot be held off. Reset clears counts and control; busy_o is
// high while the command queue is full.
module minkowski_sum_convex_hull #(
  parameter int MaxVerts  = msch_pkg::MaxVertsDef,
  parameter int CoordBits = msch_pkg::CoordBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic                 func_i,
  input  logic [CoordBits-1:0] vertex_x_i,
  input  logic [CoordBits-1:0] vertex_y_i,
  input  logic                 final_vertex_i,
  output logic                 hull_valid_o,
  output logic [CoordBits:0]   hull_x_o,
  output logic [CoordBits:0]   hull_y_o,
  output logic                 hull_empty_o,
  output logic                 overflowed_o,
  output logic                 last_of_hull_o
);
  logic q_valid, q_pop, q_func, q_final, q_full, idle;
  logic [CoordBits:0] q_x, q_y;

  assign busy_o = q_full;

  msch_front #(.CoordBits(CoordBits)) u_front (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .func_i, .vertex_x_i, .vertex_y_i,
    .final_vertex_i, .q_valid_o(q_valid), .q_pop_i(q_pop), .q_func_o(q_func),
    .q_x_o(q_x), .q_y_o(q_y), .q_final_o(q_final), .q_full_o(q_full));

  msch_back #(.MaxVerts(MaxVerts), .CoordBits(CoordBits)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_func_i(q_func),
    .q_x_i(q_x), .q_y_i(q_y), .q_final_i(q_final), .idle_o(idle),
    .done_o(hull_valid_o), .hull_x_o, .hull_y_o, .hull_empty_o, .overflowed_o,
    .last_of_hull_o);

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> (q_valid && idle)) else $error("bad pop");
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hull_valid_o |-> !idle) else $error("result while idle");
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hull_valid_o && hull_empty_o) |-> last_of_hull_o) else $error("empty not last");
endmodule
